// ===== hw/rtl/zs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_pkg: shared types and constants for the z-score standardiser
// Widths, request and result codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package zs_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = ADDR_W + 1;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 21;
    localparam int SUM_W  = 34;
    localparam int SQ_W   = 58;
    localparam int PSQ_W  = 2 * IN_W - 1;   // one square, at most 2^46
    localparam int VAR_W  = PSQ_W + 1;      // signed variance
    localparam int SD_W   = VAR_W / 2;      // root of the variance
    localparam int INV_W  = 32;
    localparam int DVD_W  = SQ_W;           // divider dividend and quotient
    localparam int DVS_W  = SD_W;           // divider divisor
    localparam int RND_SH = 20;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_READ    = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        DIV_MEAN = 2'd0,
        DIV_VAR  = 2'd1,
        DIV_INV  = 2'd2
    } t_div_sel;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_LOAD   = 14'b00000000000010,
        S_ACC    = 14'b00000000000100,
        S_CHK    = 14'b00000000001000,
        S_DMEAN  = 14'b00000000010000,
        S_DVAR   = 14'b00000000100000,
        S_VCHK   = 14'b00000001000000,
        S_SQRT   = 14'b00000010000000,
        S_DINV   = 14'b00000100000000,
        S_STATUS = 14'b00001000000000,
        S_RDMEM  = 14'b00010000000000,
        S_RDMUL  = 14'b00100000000000,
        S_RDOUT  = 14'b01000000000000,
        S_SPARE  = 14'b10000000000000
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     load;
        logic     accum;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_mean;
        logic     take_var;
        logic     sqrt_start;
        logic     take_inv;
        logic     fail;
        logic     status_out;
        logic     rd_mem;
        logic     rd_mul;
        logic     rd_out;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic last;
        logic few;
        logic var_pos;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/zs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_req_if / zs_res_if: request and result channels
// Valid/ready channels carrying one request or one result.
// ----------------------------------------------------------------------------
interface zs_req_if import zs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic signed [IN_W-1:0] sample;
    logic                   sample_missing;
    logic                   load_last;
    logic [ADDR_W-1:0]      read_index;

    modport source (output valid, req_type, sample, sample_missing, load_last, read_index,
                    input ready);
    modport sink (input valid, req_type, sample, sample_missing, load_last, read_index,
                  output ready);
endinterface

interface zs_res_if import zs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    result_kind;
    logic signed [OUT_W-1:0] out_value;
    logic                    out_missing;
    logic                    applied;
    logic [POS_W-1:0]        present_count;

    modport source (output valid, result_kind, out_value, out_missing, applied, present_count,
                    input ready);
    modport sink (input valid, result_kind, out_value, out_missing, applied, present_count,
                  output ready);
endinterface

// ===== hw/rtl/zscore_standardiser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zscore_standardiser: z-score standardisation of one stored data set
// Loads accumulate sum, sum of squares and count; the last load computes
// mean and inverse deviation; reads return the stored sample, scaled if applied.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  i_req     in   req_type, sample, sample_missing, load_last, read_index
//  o_res     out  result_kind, out_value, out_missing, applied, present_count
//
//  A load that is not last gives no result. A last load that succeeds
//  makes three passes of the one-bit-per-cycle divider and one of the
//  one-bit-per-cycle root unit.
//  A read goes through store read, multiply, round and register.
//  Reset clears control and accumulators; the store is not cleared.
//  A result waits in the output register; a stalled output holds the block.
// ----------------------------------------------------------------------------
module zscore_standardiser import zs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    zs_req_if.sink   i_req,
    zs_res_if.source o_res
);
    t_cmd cmd;
    t_sts sts;

    zs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    zs_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req.req_type),
        .i_sample         (i_req.sample),
        .i_sample_missing (i_req.sample_missing),
        .i_load_last      (i_req.load_last),
        .i_read_index     (i_req.read_index),
        .o_valid          (o_res.valid),
        .i_ready          (o_res.ready),
        .o_result_kind    (o_res.result_kind),
        .o_out_value      (o_res.out_value),
        .o_out_missing    (o_res.out_missing),
        .o_applied        (o_res.applied),
        .o_present_count  (o_res.present_count)
    );
endmodule

// ===== hw/rtl/zs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zs_div import zs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   trial;
    logic             ge;

    assign trial = {r_rem[DVS_W-1:0], r_q[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? trial - {1'b0, r_d} : trial;
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// ===== hw/rtl/zs_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_sqrt: iterative integer square root
// Digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module zs_sqrt import zs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAR_W-1:0] i_value,
    output logic             o_done,
    output logic [SD_W-1:0]  o_root
);
    localparam int CNT_W = $clog2(SD_W + 1);

    logic [VAR_W-1:0] r_v;
    logic [VAR_W-1:0] r_r;
    logic [VAR_W-1:0] r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VAR_W-1:0] rb;

    assign rb = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
            r_r <= '0;
            r_b <= VAR_W'(1) << (VAR_W - 2);
        end else if (r_busy) begin
            if (r_v >= rb) begin
                r_v <= r_v - rb;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SD_W-1:0];
endmodule

// ===== hw/rtl/zs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_ctrl: controller for the z-score standardiser
// Sequences loads, data set closing and reads through the datapath.
// ----------------------------------------------------------------------------
module zs_ctrl import zs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.is_read) begin
                    n_state = S_RDMEM;
                end else begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = i_sts.last ? S_CHK : S_IDLE;
            end
            S_CHK: begin
                if (i_sts.few) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_STATUS;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_MEAN;
                    n_state         = S_DMEAN;
                end
            end
            S_DMEAN: begin
                if (i_sts.div_done) begin
                    o_cmd.take_mean = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_VAR;
                    n_state         = S_DVAR;
                end
            end
            S_DVAR: begin
                if (i_sts.div_done) begin
                    o_cmd.take_var = 1'b1;
                    n_state        = S_VCHK;
                end
            end
            S_VCHK: begin
                if (!i_sts.var_pos) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_STATUS;
                end else begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_INV;
                    n_state         = S_DINV;
                end
            end
            S_DINV: begin
                if (i_sts.div_done) begin
                    o_cmd.take_inv = 1'b1;
                    n_state        = S_STATUS;
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.status_out = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_RDMEM: begin
                o_cmd.rd_mem = 1'b1;
                n_state      = S_RDMUL;
            end
            S_RDMUL: begin
                o_cmd.rd_mul = 1'b1;
                n_state      = S_RDOUT;
            end
            S_RDOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.rd_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/zs_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_dpath: datapath for the z-score standardiser
// Sample store, accumulators, mean/deviation units, read scaling and the
// result register.
// ----------------------------------------------------------------------------
module zs_dpath import zs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_req_type,
    input  logic signed [IN_W-1:0]  i_sample,
    input  logic                    i_sample_missing,
    input  logic                    i_load_last,
    input  logic [ADDR_W-1:0]       i_read_index,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_result_kind,
    output logic signed [OUT_W-1:0] o_out_value,
    output logic                    o_out_missing,
    output logic                    o_applied,
    output logic [POS_W-1:0]        o_present_count
);
    localparam int DMAG_W = IN_W + 1;
    localparam int PROD_W = DMAG_W + INV_W;
    localparam int RQ_W   = PROD_W - RND_SH;

    // request capture
    logic                   r_req;
    logic signed [IN_W-1:0] r_x;
    logic                   r_miss;
    logic                   r_last;
    logic [ADDR_W-1:0]      r_idx;

    // data set state
    logic [IN_W:0]           mem [DEPTH];
    logic [POS_W-1:0]        r_pos;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sumsq;
    logic [POS_W-1:0]        r_cnt;
    logic [PSQ_W-1:0]        r_sq;
    logic signed [IN_W-1:0]  r_mean;
    logic [INV_W-1:0]        r_inv;
    logic                    r_apply;

    // closing temporaries
    logic signed [IN_W-1:0]  r_mean_t;
    logic [PSQ_W-1:0]        r_msq;
    logic signed [VAR_W-1:0] r_var;

    // read pipeline
    logic signed [IN_W-1:0]  r_rd_val;
    logic                    r_rd_miss;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_neg;

    // result register
    logic                    r_ovalid;
    logic                    r_okind;
    logic signed [OUT_W-1:0] r_oval;
    logic                    r_omiss;
    logic                    r_oapp;
    logic [POS_W-1:0]        r_ocnt;

    logic                    pos_ok;
    logic signed [2*IN_W-1:0] sq_full;
    logic [SUM_W-1:0]        sum_mag;
    logic [DVD_W-1:0]        dvd;
    logic [DVS_W-1:0]        dvs;
    logic                    div_done;
    logic [DVD_W-1:0]        quo;
    logic                    sqrt_done;
    logic [SD_W-1:0]         root;
    logic [IN_W-1:0]         q_mean;
    logic signed [DMAG_W-1:0] diff;
    logic [DMAG_W-1:0]       dmag;
    logic [RQ_W-1:0]         rq;
    logic signed [OUT_W-1:0] scaled;
    logic signed [OUT_W-1:0] raw_sat;
    logic                    out_free;

    assign pos_ok  = r_pos < POS_W'(DEPTH);
    assign sq_full = r_x * r_x;
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign q_mean  = quo[IN_W-1:0];

    always_comb begin
        dvd = '0;
        dvs = '0;
        unique case (i_cmd.div_sel)
            DIV_MEAN: begin
                dvd = DVD_W'(sum_mag) + DVD_W'(r_cnt >> 1);
                dvs = DVS_W'(r_cnt);
            end
            DIV_VAR: begin
                dvd = r_sumsq;
                dvs = DVS_W'(r_cnt);
            end
            DIV_INV: begin
                dvd = (DVD_W'(1) << INV_W) + DVD_W'(root >> 1);
                dvs = root;
            end
            default: begin
                dvd = '0;
                dvs = '0;
            end
        endcase
    end

    zs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    zs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (VAR_W'(r_var)),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    assign diff = DMAG_W'(r_rd_val) - DMAG_W'(r_mean);
    assign dmag = diff[DMAG_W-1] ? DMAG_W'(-diff) : DMAG_W'(diff);
    assign rq   = RQ_W'((r_prod + (PROD_W'(1) << (RND_SH - 1))) >> RND_SH);

    // round half away from zero, then clip to the Q8.12 range
    always_comb begin
        if (!r_neg && rq > RQ_W'({1'b0, {(OUT_W-1){1'b1}}})) begin
            scaled = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (r_neg && rq > RQ_W'({1'b1, {(OUT_W-1){1'b0}}})) begin
            scaled = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            scaled = r_neg ? OUT_W'(-rq) : OUT_W'(rq);
        end
    end

    always_comb begin
        if (r_rd_val > IN_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) begin
            raw_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (r_rd_val < IN_W'(signed'({1'b1, {(OUT_W-1){1'b0}}}))) begin
            raw_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            raw_sat = r_rd_val[OUT_W-1:0];
        end
    end

    assign out_free = !r_ovalid || i_ready;

    // request and temporaries
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_x    <= i_sample;
            r_miss <= i_sample_missing;
            r_last <= i_load_last;
            r_idx  <= i_read_index;
        end
        if (i_cmd.load) begin
            r_sq <= sq_full[PSQ_W-1:0];
        end
        if (i_cmd.take_mean) begin
            r_mean_t <= r_sum[SUM_W-1] ? IN_W'(-q_mean) : q_mean;
            r_msq    <= PSQ_W'(q_mean * q_mean);
        end
        if (i_cmd.take_var) begin
            r_var <= VAR_W'(quo[PSQ_W-1:0]) - VAR_W'(r_msq);
        end
        if (i_cmd.rd_mem) begin
            {r_rd_miss, r_rd_val} <= mem[r_idx];
        end
        if (i_cmd.rd_mul) begin
            r_prod <= PROD_W'(dmag) * PROD_W'(r_inv);
            r_neg  <= diff[DMAG_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && pos_ok) begin
            mem[r_pos[ADDR_W-1:0]] <= {r_miss, r_x};
        end
    end

    // data set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_cnt   <= '0;
            r_mean  <= '0;
            r_inv   <= '0;
            r_apply <= 1'b0;
        end else begin
            if (i_cmd.accum && pos_ok) begin
                r_pos <= r_pos + 1'b1;
                if (!r_miss) begin
                    r_sum   <= r_sum + SUM_W'(r_x);
                    r_sumsq <= r_sumsq + SQ_W'(r_sq);
                    r_cnt   <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.fail) begin
                r_mean  <= '0;
                r_inv   <= '0;
                r_apply <= 1'b0;
            end
            if (i_cmd.take_inv) begin
                r_mean  <= r_mean_t;
                r_inv   <= (quo[DVD_W-1:INV_W] != '0) ? '1 : quo[INV_W-1:0];
                r_apply <= 1'b1;
            end
            // close the data set
            if (i_cmd.status_out) begin
                r_pos   <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
                r_cnt   <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.status_out || i_cmd.rd_out) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.status_out) begin
            r_okind <= KIND_STATUS;
            r_oval  <= '0;
            r_omiss <= 1'b0;
            r_oapp  <= r_apply;
            r_ocnt  <= r_cnt;
        end else if (i_cmd.rd_out) begin
            r_okind <= KIND_READ;
            r_omiss <= r_rd_miss;
            r_oapp  <= r_apply;
            r_ocnt  <= '0;
            if (r_rd_miss) begin
                r_oval <= '0;
            end else begin
                r_oval <= r_apply ? scaled : raw_sat;
            end
        end
    end

    assign o_sts.is_read   = (r_req == REQ_READ);
    assign o_sts.last      = r_last;
    assign o_sts.few       = r_cnt < POS_W'(2);
    assign o_sts.var_pos   = !r_var[VAR_W-1] && (r_var != '0);
    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sqrt_done;
    assign o_sts.out_free  = out_free;

    assign o_valid         = r_ovalid;
    assign o_result_kind   = r_okind;
    assign o_out_value     = r_oval;
    assign o_out_missing   = r_omiss;
    assign o_applied       = r_oapp;
    assign o_present_count = r_ocnt;
endmodule

// ===== hw/rtl/zs_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_chk: port checker for the z-score standardiser
// Checks result channel behavior as seen on the top level ports.
// ----------------------------------------------------------------------------
module zs_chk import zs_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_res_valid,
    input logic                    i_res_ready,
    input logic                    i_result_kind,
    input logic signed [OUT_W-1:0] i_out_value,
    input logic                    i_out_missing,
    input logic [POS_W-1:0]        i_present_count
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_result_kind == KIND_STATUS |-> i_out_value == '0 && !i_out_missing)
        else $error("status result carries data");

    a_readcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_result_kind == KIND_READ |-> i_present_count == '0)
        else $error("read result carries a count");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_out_missing |-> i_out_value == '0)
        else $error("missing sample with nonzero value");
endmodule

bind zscore_standardiser zs_chk u_zs_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_result_kind   (o_res.result_kind),
    .i_out_value     (o_res.out_value),
    .i_out_missing   (o_res.out_missing),
    .i_present_count (o_res.present_count)
);
